/* src/alle_pkg.sv */
// Package with the shared types, constants and helpers of the linked list engine.
`timescale 1ns / 1ps

package alle_pkg;

  localparam int ENTRY_COUNT = 16;
  localparam int IDX_W       = $clog2(ENTRY_COUNT);
  localparam int CNT_W       = IDX_W + 1;
  localparam int MODE_W      = 3;
  localparam int SLOT_W      = 5;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;

  typedef logic        [IDX_W-1:0]  idx_t;
  typedef logic        [CNT_W-1:0]  cnt_t;
  typedef logic signed [SLOT_W-1:0] slot_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam slot_t NULL_SLOT  = '1;
  localparam data_t EMPTY_DATA = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_HEAD = 3'd0,
    MODE_WRITE    = 3'd1,
    MODE_INSERT   = 3'd2,
    MODE_DELETE   = 3'd3,
    MODE_SEARCH   = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SLOT   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EVAL,
    S_INS_NEW,
    S_INS_LINK,
    S_RELINK,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    slot_t             slot;
    data_t             key_value;
    data_t             new_value;
    slot_t             link_index;
  } cmd_t;

  // True when the index names an entry of the table.
  function automatic logic idx_ok(slot_t s);
    return !s[SLOT_W-1] && (32'(unsigned'(s)) < ENTRY_COUNT);
  endfunction

endpackage

/* src/alle_in_if.sv */
// Command channel of the linked list engine.
`timescale 1ns / 1ps

interface alle_in_if import alle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  slot_t             slot;
  data_t             key_value;
  data_t             new_value;
  slot_t             link_index;

  modport source (output valid, mode, slot, key_value, new_value, link_index,
                  input ready);
  modport sink   (input valid, mode, slot, key_value, new_value, link_index,
                  output ready);
endinterface

/* src/alle_out_if.sv */
// Result channel of the linked list engine.
`timescale 1ns / 1ps

interface alle_out_if import alle_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  slot_t   found_slot;
  slot_t   list_head;

  modport source (output valid, status, found_slot, list_head, input ready);
  modport sink   (input valid, status, found_slot, list_head, output ready);
endinterface

/* src/array_linked_list_engine.sv */
// Top level of the array-backed singly linked list engine.
`timescale 1ns / 1ps

// The engine keeps a table of ENTRY_COUNT entries (data word and next index) in
// one memory with a single read port, scanned one entry per cycle by a small
// sequencer. Set head, write entry and unused modes finish without a scan.
// Search, insert and delete scan the whole table; a successful insert then
// writes the new entry and relinks the match, and a successful delete
// scans the table a second time to relink predecessors and then clears the
// entry. A new command is accepted only once the previous one has produced
// its result; the result is loaded into an output register, and the engine
// waits in its done state while an earlier result has not yet been taken.
// Reset empties the table at once through per-entry valid flags, so there is
// no clearing pass: an entry never written reads as empty with a null link.
module array_linked_list_engine import alle_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  alle_in_if.sink       in_chan,
  alle_out_if.source    out_chan
);

  // Entry table and its valid flags.
  data_t data_mem [ENTRY_COUNT];
  slot_t link_mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] vld_r;

  data_t rd_data_r;
  slot_t rd_link_r;
  logic  rd_ok_r;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  slot_t  head_r, head_nxt;
  status_t status_r, status_nxt;
  slot_t  found_r, found_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   rd_pend_r, rd_pend_nxt;
  idx_t   rd_idx_r, rd_idx_nxt;
  logic   first_hit_r, first_hit_nxt;
  idx_t   first_idx_r, first_idx_nxt;
  slot_t  first_link_r, first_link_nxt;
  logic   last_hit_r, last_hit_nxt;
  idx_t   last_idx_r, last_idx_nxt;
  slot_t  last_link_r, last_link_nxt;
  logic   nbr_empty_r, nbr_empty_nxt;

  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  slot_t   out_found_r, out_found_nxt;
  slot_t   out_head_r, out_head_nxt;

  logic  wr_data_en, wr_link_en, clr_en;
  idx_t  wr_addr;
  data_t wr_data;
  slot_t wr_link;

  data_t eff_data;
  slot_t eff_link;
  logic  hit;
  logic  scan_end;
  idx_t  ins_idx;
  logic  in_acc;
  logic  out_load;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  // An entry that was never written reads as empty with a null link.
  assign eff_data = rd_ok_r ? rd_data_r : EMPTY_DATA;
  assign eff_link = rd_ok_r ? rd_link_r : NULL_SLOT;
  assign hit      = (eff_data == cmd_r.key_value);
  assign scan_end = (cnt_r == CNT_W'(ENTRY_COUNT)) && !rd_pend_r;
  assign ins_idx  = first_idx_r + IDX_W'(1);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_r.mode == MODE_INSERT || cmd_r.mode == MODE_DELETE ||
            cmd_r.mode == MODE_SEARCH) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_end) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        if (cmd_r.mode == MODE_INSERT && first_hit_r &&
            first_idx_r != IDX_W'(ENTRY_COUNT - 1) && nbr_empty_r) begin
          state_nxt = S_INS_NEW;
        end else if (cmd_r.mode == MODE_DELETE && last_hit_r) begin
          state_nxt = S_RELINK;
        end
      end
      S_INS_NEW:  state_nxt = S_INS_LINK;
      S_INS_LINK: state_nxt = S_DONE;
      S_RELINK: begin
        if (scan_end) state_nxt = S_CLEAR;
      end
      S_CLEAR: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cmd_nxt        = cmd_r;
    head_nxt       = head_r;
    status_nxt     = status_r;
    found_nxt      = found_r;
    cnt_nxt        = cnt_r;
    rd_pend_nxt    = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    first_hit_nxt  = first_hit_r;
    first_idx_nxt  = first_idx_r;
    first_link_nxt = first_link_r;
    last_hit_nxt   = last_hit_r;
    last_idx_nxt   = last_idx_r;
    last_link_nxt  = last_link_r;
    nbr_empty_nxt  = nbr_empty_r;
    wr_data_en     = 1'b0;
    wr_link_en     = 1'b0;
    clr_en         = 1'b0;
    wr_addr        = first_idx_r;
    wr_data        = cmd_r.new_value;
    wr_link        = NULL_SLOT;

    // The read side of a scan: issue one address a cycle, tag the returning data.
    if ((state_r == S_SCAN || state_r == S_RELINK) &&
        cnt_r != CNT_W'(ENTRY_COUNT)) begin
      cnt_nxt     = cnt_r + CNT_W'(1);
      rd_pend_nxt = 1'b1;
      rd_idx_nxt  = cnt_r[IDX_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt.mode       = in_chan.mode;
          cmd_nxt.slot       = in_chan.slot;
          cmd_nxt.key_value  = in_chan.key_value;
          cmd_nxt.new_value  = in_chan.new_value;
          cmd_nxt.link_index = in_chan.link_index;
        end
      end
      S_EXEC: begin
        status_nxt    = ST_DONE;
        found_nxt     = NULL_SLOT;
        cnt_nxt       = '0;
        first_hit_nxt = 1'b0;
        last_hit_nxt  = 1'b0;
        nbr_empty_nxt = 1'b0;
        unique case (cmd_r.mode)
          MODE_SET_HEAD: begin
            if (cmd_r.slot == NULL_SLOT || idx_ok(cmd_r.slot)) begin
              head_nxt  = cmd_r.slot;
              found_nxt = cmd_r.slot;
            end else begin
              status_nxt = ST_NO_SLOT;
            end
          end
          MODE_WRITE: begin
            if (idx_ok(cmd_r.slot)) begin
              wr_data_en = 1'b1;
              wr_link_en = 1'b1;
              wr_addr    = IDX_W'(unsigned'(cmd_r.slot));
              wr_link    = idx_ok(cmd_r.link_index) ? cmd_r.link_index : NULL_SLOT;
              found_nxt  = cmd_r.slot;
            end else begin
              status_nxt = ST_NO_SLOT;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (rd_pend_r) begin
          // The neighbor check relies on the first hit being registered before the neighbor's data returns.
          if (first_hit_r && rd_idx_r == ins_idx) begin
            nbr_empty_nxt = (eff_data == EMPTY_DATA);
          end
          if (hit && !first_hit_r) begin
            first_hit_nxt  = 1'b1;
            first_idx_nxt  = rd_idx_r;
            first_link_nxt = eff_link;
          end
          if (hit) begin
            last_hit_nxt  = 1'b1;
            last_idx_nxt  = rd_idx_r;
            last_link_nxt = eff_link;
          end
        end
      end
      S_EVAL: begin
        cnt_nxt = '0;
        unique case (cmd_r.mode)
          MODE_DELETE: begin
            if (!last_hit_r) status_nxt = ST_NOT_FOUND;
          end
          MODE_INSERT: begin
            if (!first_hit_r) begin
              status_nxt = ST_NOT_FOUND;
            end else if (first_idx_r == IDX_W'(ENTRY_COUNT - 1) || !nbr_empty_r) begin
              status_nxt = ST_NO_SLOT;
            end
          end
          default: begin
            if (first_hit_r) begin
              found_nxt = SLOT_W'(first_idx_r);
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
        endcase
      end
      S_INS_NEW: begin
        wr_data_en = 1'b1;
        wr_link_en = 1'b1;
        wr_addr    = ins_idx;
        wr_data    = cmd_r.new_value;
        wr_link    = first_link_r;
        found_nxt  = SLOT_W'(ins_idx);
      end
      S_INS_LINK: begin
        // The match holds the key, so writing the key back keeps its data.
        wr_data_en = 1'b1;
        wr_link_en = 1'b1;
        wr_addr    = first_idx_r;
        wr_data    = cmd_r.key_value;
        wr_link    = SLOT_W'(ins_idx);
      end
      S_RELINK: begin
        if (rd_pend_r && eff_link == SLOT_W'(last_idx_r)) begin
          wr_link_en = 1'b1;
          wr_addr    = rd_idx_r;
          wr_link    = last_link_r;
        end
      end
      S_CLEAR: begin
        clr_en    = 1'b1;
        wr_addr   = last_idx_r;
        found_nxt = SLOT_W'(last_idx_r);
        if (head_r == SLOT_W'(last_idx_r)) head_nxt = last_link_r;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_head_nxt   = out_head_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_found_nxt  = found_r;
      out_head_nxt   = head_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.found_slot = out_found_r;
  assign out_chan.list_head  = out_head_r;

  // Entry table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_data_en) data_mem[wr_addr] <= wr_data;
    if (wr_link_en) link_mem[wr_addr] <= wr_link;
    rd_data_r <= data_mem[cnt_r[IDX_W-1:0]];
    rd_link_r <= link_mem[cnt_r[IDX_W-1:0]];
    rd_ok_r   <= vld_r[cnt_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      state_r     <= S_IDLE;
      head_r      <= NULL_SLOT;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_data_en || wr_link_en) vld_r[wr_addr] <= 1'b1;
      else if (clr_en)              vld_r[wr_addr] <= 1'b0;
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    rd_idx_r     <= rd_idx_nxt;
    first_hit_r  <= first_hit_nxt;
    first_idx_r  <= first_idx_nxt;
    first_link_r <= first_link_nxt;
    last_hit_r   <= last_hit_nxt;
    last_idx_r   <= last_idx_nxt;
    last_link_r  <= last_link_nxt;
    nbr_empty_r  <= nbr_empty_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_head_r   <= out_head_nxt;
  end

  a_accept_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EXEC)
    else $error("accepted item did not start execution");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_nxt && !out_valid_r |-> state_r == S_DONE)
    else $error("result loaded outside the done state");

  a_fail_has_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_DONE |-> out_found_r == NULL_SLOT)
    else $error("failed command reports an entry");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r == NULL_SLOT || idx_ok(head_r))
    else $error("head index out of range");

  a_write_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_data_en || wr_link_en || clr_en |-> state_r != S_IDLE && state_r != S_DONE)
    else $error("table written while idle");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the array-backed linked list engine.
`timescale 1ns / 1ps

module testbench;
  import alle_pkg::*;

  typedef struct packed {
    status_t status;
    slot_t   found_slot;
    slot_t   list_head;
  } list_result_t;

  typedef struct {
    cmd_t         cmd;
    bit           typed;
    list_result_t want;
  } stim_row_t;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_SEARCH + 1'b1;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = '1;
  localparam slot_t LAST_SLOT = slot_t'(ENTRY_COUNT - 1);
  localparam data_t MAX_POS   = 32'h7FFF_FFFF;
  localparam data_t MIN_NEG   = 32'h8000_0000;
  localparam int    OP_CYCLES = 2 * ENTRY_COUNT + 9;
  localparam int    ITEMS_PER_PHASE = 360;

  localparam data_t VALUE_POOL [8] = '{
    32'h0000_0000, 32'h0000_0001, MAX_POS, MIN_NEG,
    32'hA5A5_5A5A, 32'h1234_5678, 32'hFFFF_FFFE, 32'h0000_0010
  };

  // Typed rows hold results that follow directly from reset, the command alone or an error path.
  stim_row_t directed_rows [25] = '{
    '{'{MODE_SEARCH, NULL_SLOT, EMPTY_DATA, 32'h0, NULL_SLOT}, 1'b1,
      '{ST_DONE, slot_t'(0), NULL_SLOT}},
    '{'{MODE_SEARCH, NULL_SLOT, 32'h5, 32'h0, NULL_SLOT}, 1'b1,
      '{ST_NOT_FOUND, NULL_SLOT, NULL_SLOT}},
    '{'{MODE_SET_HEAD, LAST_SLOT, 32'h0, 32'h0, NULL_SLOT}, 1'b1,
      '{ST_DONE, LAST_SLOT, LAST_SLOT}},
    '{'{MODE_SET_HEAD, slot_t'(-2), 32'h0, 32'h0, NULL_SLOT}, 1'b1,
      '{ST_NO_SLOT, NULL_SLOT, LAST_SLOT}},
    '{'{MODE_SET_HEAD, slot_t'(-16), 32'h0, 32'h0, NULL_SLOT}, 1'b1,
      '{ST_NO_SLOT, NULL_SLOT, LAST_SLOT}},
    '{'{MODE_SET_HEAD, NULL_SLOT, 32'h0, 32'h0, NULL_SLOT}, 1'b1,
      '{ST_DONE, NULL_SLOT, NULL_SLOT}},
    '{'{MODE_WRITE, slot_t'(0), 32'h0, MAX_POS, LAST_SLOT}, 1'b1,
      '{ST_DONE, slot_t'(0), NULL_SLOT}},
    '{'{MODE_WRITE, LAST_SLOT, 32'h0, MIN_NEG, NULL_SLOT}, 1'b1,
      '{ST_DONE, LAST_SLOT, NULL_SLOT}},
    '{'{MODE_WRITE, NULL_SLOT, 32'h0, 32'h1, NULL_SLOT}, 1'b1,
      '{ST_NO_SLOT, NULL_SLOT, NULL_SLOT}},
    '{'{MODE_WRITE, slot_t'(-11), 32'h0, 32'h0, slot_t'(3)}, 1'b1,
      '{ST_NO_SLOT, NULL_SLOT, NULL_SLOT}},
    '{'{MODE_WRITE, slot_t'(3), 32'h0, 32'h64, slot_t'(-3)}, 1'b0, '0},
    '{'{MODE_SET_HEAD, slot_t'(0), 32'h0, 32'h0, NULL_SLOT}, 1'b1,
      '{ST_DONE, slot_t'(0), slot_t'(0)}},
    '{'{MODE_INSERT, NULL_SLOT, MAX_POS, 32'hA5A5_5A5A, NULL_SLOT}, 1'b0, '0},
    '{'{MODE_INSERT, NULL_SLOT, MIN_NEG, 32'h2, NULL_SLOT}, 1'b1,
      '{ST_NO_SLOT, NULL_SLOT, slot_t'(0)}},
    '{'{MODE_INSERT, NULL_SLOT, 32'h3039, 32'h2, NULL_SLOT}, 1'b1,
      '{ST_NOT_FOUND, NULL_SLOT, slot_t'(0)}},
    '{'{MODE_INSERT, NULL_SLOT, MAX_POS, 32'h1, NULL_SLOT}, 1'b0, '0},
    '{'{MODE_SEARCH, NULL_SLOT, 32'hA5A5_5A5A, 32'h0, NULL_SLOT}, 1'b0, '0},
    '{'{MODE_DELETE, NULL_SLOT, 32'hA5A5_5A5A, 32'h0, NULL_SLOT}, 1'b0, '0},
    '{'{MODE_DELETE, NULL_SLOT, MAX_POS, 32'h0, NULL_SLOT}, 1'b0, '0},
    '{'{MODE_DELETE, NULL_SLOT, 32'h63, 32'h0, NULL_SLOT}, 1'b0, '0},
    '{'{MODE_DELETE, NULL_SLOT, EMPTY_DATA, 32'h0, NULL_SLOT}, 1'b0, '0},
    '{'{MODE_INSERT, NULL_SLOT, EMPTY_DATA, EMPTY_DATA, NULL_SLOT}, 1'b0, '0},
    '{'{MODE_SPARE_LO, LAST_SLOT, MAX_POS, MIN_NEG, LAST_SLOT}, 1'b0, '0},
    '{'{MODE_SPARE_HI, NULL_SLOT, EMPTY_DATA, EMPTY_DATA, NULL_SLOT}, 1'b0, '0},
    '{'{MODE_WRITE, slot_t'(2), 32'h0, 32'h0, slot_t'(-16)}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  alle_in_if  in_chan ();
  alle_out_if out_chan ();

  array_linked_list_engine u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #1 clk = ~clk;

  // Shadow copy of the table, kept in step with accepted commands.
  data_t tbl_data [ENTRY_COUNT];
  slot_t tbl_link [ENTRY_COUNT];
  slot_t head_q;

  list_result_t expected_results [$];
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_plan  [4] = '{0, 46, 0, 12};
  int stall_plan [4] = '{0, 0, 46, 12};

  function automatic bit in_table(slot_t s);
    return (s >= 0) && (int'(s) < ENTRY_COUNT);
  endfunction

  function automatic int match_at(data_t key, bit want_last);
    int hit;
    hit = -1;
    for (int k = 0; k < ENTRY_COUNT; k++) begin
      if (tbl_data[k] == key) begin
        if (!want_last) return k;
        hit = k;
      end
    end
    return hit;
  endfunction

  function automatic list_result_t apply_command(cmd_t c);
    list_result_t r;
    int m;
    slot_t nxt;
    r.status = ST_DONE;
    r.found_slot = NULL_SLOT;
    case (c.mode)
      MODE_SET_HEAD: begin
        if (c.slot == NULL_SLOT || in_table(c.slot)) begin
          head_q = c.slot;
          r.found_slot = c.slot;
        end else begin
          r.status = ST_NO_SLOT;
        end
      end
      MODE_WRITE: begin
        if (in_table(c.slot)) begin
          tbl_data[idx_t'(c.slot)] = c.new_value;
          tbl_link[idx_t'(c.slot)] = in_table(c.link_index) ? c.link_index : NULL_SLOT;
          r.found_slot = c.slot;
        end else begin
          r.status = ST_NO_SLOT;
        end
      end
      MODE_INSERT: begin
        m = match_at(c.key_value, 1'b0);
        if (m < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (m + 1 >= ENTRY_COUNT || tbl_data[m + 1] != EMPTY_DATA) begin
          r.status = ST_NO_SLOT;
        end else begin
          tbl_link[m + 1] = tbl_link[m];
          tbl_link[m] = slot_t'(m + 1);
          tbl_data[m + 1] = c.new_value;
          r.found_slot = slot_t'(m + 1);
        end
      end
      MODE_DELETE: begin
        m = match_at(c.key_value, 1'b1);
        if (m < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // Every predecessor, including the head, skips over the victim.
          nxt = tbl_link[m];
          for (int k = 0; k < ENTRY_COUNT; k++) begin
            if (tbl_link[k] == slot_t'(m)) tbl_link[k] = nxt;
          end
          if (head_q == slot_t'(m)) head_q = nxt;
          tbl_data[m] = EMPTY_DATA;
          tbl_link[m] = NULL_SLOT;
          r.found_slot = slot_t'(m);
        end
      end
      MODE_SEARCH: begin
        m = match_at(c.key_value, 1'b0);
        if (m < 0) r.status = ST_NOT_FOUND;
        else r.found_slot = slot_t'(m);
      end
      default: begin
      end
    endcase
    r.list_head = head_q;
    return r;
  endfunction

  // Values lean on a small pool so that keys keep hitting stored entries.
  function automatic data_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return VALUE_POOL[$urandom_range(0, 7)];
    if (r < 80) return EMPTY_DATA;
    return data_t'($urandom);
  endfunction

  function automatic slot_t pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return slot_t'($urandom_range(0, ENTRY_COUNT - 1));
    if (r < 90) return NULL_SLOT;
    return slot_t'($urandom);
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)      c.mode = MODE_SET_HEAD;
    else if (r < 35) c.mode = MODE_WRITE;
    else if (r < 55) c.mode = MODE_INSERT;
    else if (r < 75) c.mode = MODE_DELETE;
    else if (r < 95) c.mode = MODE_SEARCH;
    else c.mode = MODE_SPARE_LO + MODE_W'($urandom_range(0, MODE_SPARE_HI - MODE_SPARE_LO));
    c.slot = pick_index();
    c.link_index = pick_index();
    c.key_value = pick_value();
    c.new_value = pick_value();
    return c;
  endfunction

  task automatic send_command(cmd_t c, bit typed, list_result_t typed_res);
    list_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.mode       <= c.mode;
    in_chan.slot       <= c.slot;
    in_chan.key_value  <= c.key_value;
    in_chan.new_value  <= c.new_value;
    in_chan.link_index <= c.link_index;
    do @(posedge clk); while (!in_chan.ready);
    predicted = apply_command(c);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Holds the command channel quiet until every pending result is back.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.status, out_chan.found_slot, out_chan.list_head};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %0d found %0d head %0d",
                 $time, got.status, got.found_slot, got.list_head);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: status/found/head expected %0d/%0d/%0d got %0d/%0d/%0d",
                   $time, want.status, want.found_slot, want.list_head,
                   got.status, got.found_slot, got.list_head);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.mode       <= MODE_SET_HEAD;
    in_chan.slot       <= NULL_SLOT;
    in_chan.key_value  <= '0;
    in_chan.new_value  <= '0;
    in_chan.link_index <= NULL_SLOT;
    for (int k = 0; k < ENTRY_COUNT; k++) begin
      tbl_data[k] = EMPTY_DATA;
      tbl_link[k] = NULL_SLOT;
    end
    head_q = NULL_SLOT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_command(random_command(), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (OP_CYCLES + 20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
